// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

// ===== rtl/swa_pkg.sv =====
// package for the shape world aabb unit: types, constants, helpers
// no dependencies
package swa_pkg;
  localparam int PosW = 32;
  localparam int QuatW = 16;
  localparam int ExtW = 31;
  localparam int OutW = 48;
  localparam int MatW = 31;   // unsigned Q3.28 magnitude of a matrix entry, at most 2^30
  localparam int ProdW = MatW + ExtW;
  localparam int AccW = ProdW + 2;
  localparam int CfgIdxW = 3;
  localparam logic [ExtW-1:0] MinExtent = ExtW'(7);
  localparam logic [OutW-1:0] PlaneExtent = OutW'(64'd65536000000000);
  localparam logic signed [QuatW-1:0] QuatLim = 16'sd16384;

  typedef enum logic [1:0] {
    KIND_SPHERE = 2'd0,
    KIND_BOX    = 2'd1,
    KIND_PLANE  = 2'd2,
    KIND_SPARE  = 2'd3
  } shape_kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KIND   = 3'd0,
    REG_RADIUS = 3'd1,
    REG_HX     = 3'd2,
    REG_HY     = 3'd3,
    REG_HZ     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    shape_kind_t kind;
    logic [ExtW-1:0] radius;
    logic [ExtW-1:0] hx;
    logic [ExtW-1:0] hy;
    logic [ExtW-1:0] hz;
  } cfg_t;

  function automatic logic signed [QuatW-1:0] clamp_q(input logic signed [QuatW-1:0] v);
    if (v > QuatLim) return QuatLim;
    if (v < -QuatLim) return -QuatLim;
    return v;
  endfunction

  function automatic logic [ExtW-1:0] floor_ext(input logic [ExtW-1:0] v);
    return (v < MinExtent) ? MinExtent : v;
  endfunction
endpackage

// ===== rtl/swa_rot.sv =====
// rotation stage: clamped quaternion products, then |R| entries (two stages)
// depends on swa_pkg
module swa_rot (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [swa_pkg::QuatW-1:0] qw,
  input  logic signed [swa_pkg::QuatW-1:0] qx,
  input  logic signed [swa_pkg::QuatW-1:0] qy,
  input  logic signed [swa_pkg::QuatW-1:0] qz,
  output logic out_valid,
  output logic [8:0][swa_pkg::MatW-1:0] mag
);
  import swa_pkg::*;

  logic signed [QuatW-1:0] w, x, y, z;
  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  logic v1;
  logic signed [33:0] m [9];

  assign w = clamp_q(qw);
  assign x = clamp_q(qx);
  assign y = clamp_q(qy);
  assign z = clamp_q(qz);

  // stage one: the nine products
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    pxx <= x * x; pyy <= y * y; pzz <= z * z;
    pxy <= x * y; pxz <= x * z; pyz <= y * z;
    pwx <= w * x; pwy <= w * y; pwz <= w * z;
  end

  // matrix entries, row major
  always_comb begin
    m[0] = 34'sd268435456 - 2 * (34'(pyy) + 34'(pzz));
    m[1] = 2 * (34'(pxy) - 34'(pwz));
    m[2] = 2 * (34'(pxz) + 34'(pwy));
    m[3] = 2 * (34'(pxy) + 34'(pwz));
    m[4] = 34'sd268435456 - 2 * (34'(pxx) + 34'(pzz));
    m[5] = 2 * (34'(pyz) - 34'(pwx));
    m[6] = 2 * (34'(pxz) - 34'(pwy));
    m[7] = 2 * (34'(pyz) + 34'(pwx));
    m[8] = 34'sd268435456 - 2 * (34'(pxx) + 34'(pyy));
  end

  // stage two: magnitudes
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v1;
    for (int i = 0; i < 9; i++) begin
      mag[i] <= m[i][33] ? MatW'(-m[i]) : MatW'(m[i]);
    end
  end
endmodule

// ===== rtl/swa_ext.sv =====
// extent stage: |R| times half extents, row sums, rounding (two stages)
// depends on swa_pkg
module swa_ext (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [8:0][swa_pkg::MatW-1:0] mag,
  input  swa_pkg::cfg_t cfg,
  output logic out_valid,
  output logic [2:0][swa_pkg::OutW-1:0] ext
);
  import swa_pkg::*;

  logic [ExtW-1:0] h [3];
  logic [8:0][ProdW-1:0] prod;
  logic v1;
  logic [AccW-1:0] acc [3];

  assign h[0] = floor_ext(cfg.hx);
  assign h[1] = floor_ext(cfg.hy);
  assign h[2] = floor_ext(cfg.hz);

  // stage one: nine products
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    for (int i = 0; i < 9; i++) begin
      prod[i] <= ProdW'(mag[i]) * ProdW'(h[i % 3]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AccW'(prod[3*i]) + AccW'(prod[3*i+1]) + AccW'(prod[3*i+2])
             + (AccW'(1) << 27);
    end
  end

  // stage two: rounded Q32.16 extents
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v1;
    for (int i = 0; i < 3; i++) begin
      ext[i] <= OutW'(acc[i] >> 28);
    end
  end
endmodule

// ===== rtl/shape_world_aabb_unit.sv =====
// top level of the shape world aabb unit: config registers, pipeline, output stage
// depends on swa_pkg, swa_rot, swa_ext
// One transaction is accepted per cycle (busy stays low) and its bounding box
// appears on the result ports with done high after the five register stages:
// quaternion products, matrix magnitudes, extent products, row sums and the
// final add with saturation. The receiver cannot stall; results must be taken
// in the cycle done is high. Write configuration only while no transaction is
// in flight.
module shape_world_aabb_unit (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic cfg_we,
  input  logic [swa_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [30:0] cfg_data,
  output logic done,
  output logic signed [47:0] min_x,
  output logic signed [47:0] min_y,
  output logic signed [47:0] min_z,
  output logic signed [47:0] max_x,
  output logic signed [47:0] max_y,
  output logic signed [47:0] max_z
);
  import swa_pkg::*;

  localparam int Lat = 4;

  cfg_t cfg;
  logic accept;
  logic signed [PosW-1:0] pos_d [Lat][3];
  logic [8:0][MatW-1:0] mag;
  logic rot_valid, ext_valid;
  logic [2:0][OutW-1:0] box_ext;
  logic [OutW-1:0] ext_sel [3];
  logic signed [OutW:0] lo [3];
  logic signed [OutW:0] hi [3];

  assign busy = 1'b0;
  assign accept = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind <= KIND_SPHERE;
      cfg.radius <= ExtW'(65536);
      cfg.hx <= ExtW'(65536);
      cfg.hy <= ExtW'(65536);
      cfg.hz <= ExtW'(65536);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_KIND:   cfg.kind <= shape_kind_t'(cfg_data[1:0]);
        REG_RADIUS: cfg.radius <= cfg_data;
        REG_HX:     cfg.hx <= cfg_data;
        REG_HY:     cfg.hy <= cfg_data;
        REG_HZ:     cfg.hz <= cfg_data;
        default: ;
      endcase
    end
  end

  swa_rot u_rot (
    .clk(clk), .rst(rst), .in_valid(accept),
    .qw(quat_w), .qx(quat_x), .qy(quat_y), .qz(quat_z),
    .out_valid(rot_valid), .mag(mag)
  );

  swa_ext u_ext (
    .clk(clk), .rst(rst), .in_valid(rot_valid), .mag(mag), .cfg(cfg),
    .out_valid(ext_valid), .ext(box_ext)
  );

  // position delay line alongside the pipeline
  always_ff @(posedge clk) begin
    pos_d[0][0] <= pos_x;
    pos_d[0][1] <= pos_y;
    pos_d[0][2] <= pos_z;
    for (int s = 1; s < Lat; s++) begin
      pos_d[s] <= pos_d[s-1];
    end
  end

  // extent select by shape and final add/subtract; saturation follows in the output register
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (cfg.kind)
        KIND_SPHERE: ext_sel[i] = OutW'(floor_ext(cfg.radius));
        KIND_BOX:    ext_sel[i] = box_ext[i];
        default:     ext_sel[i] = PlaneExtent;
      endcase
      lo[i] = (OutW+1)'(pos_d[Lat-1][i]) - $signed({2'b00, ext_sel[i][OutW-2:0]});
      hi[i] = (OutW+1)'(pos_d[Lat-1][i]) + $signed({2'b00, ext_sel[i][OutW-2:0]});
    end
  end

  function automatic logic [OutW-1:0] sat(input logic signed [OutW:0] v);
    if (v[OutW] != v[OutW-1]) return v[OutW] ? {1'b1, {(OutW-1){1'b0}}}
                                           : {1'b0, {(OutW-1){1'b1}}};
    return v[OutW-1:0];
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= ext_valid;
    min_x <= sat(lo[0]);
    min_y <= sat(lo[1]);
    min_z <= sat(lo[2]);
    max_x <= sat(hi[0]);
    max_y <= sat(hi[1]);
    max_z <= sat(hi[2]);
  end
endmodule

// ===== rtl/swa_checker.sv =====
// port-level checker for the shape world aabb unit, bound to the top level
// depends on assert_macros.svh and shape_world_aabb_unit
`include "assert_macros.svh"
module swa_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic signed [47:0] min_x,
  input logic signed [47:0] min_y,
  input logic signed [47:0] min_z,
  input logic signed [47:0] max_x,
  input logic signed [47:0] max_y,
  input logic signed [47:0] max_z
);
  `ASSERT_IMPL(a_never_busy, clk, rst, 1'b1, !busy, "unit reported busy")
  `ASSERT_IMPL(a_latency, clk, rst, $past(start && !busy, 5) && !$past(rst, 5), done,
    "missing result five cycles after start")
  `ASSERT_IMPL(a_no_spurious, clk, rst, done && !$past(rst, 5), $past(start, 5),
    "result without a matching start")
  `ASSERT_IMPL(a_ordered, clk, rst, done,
    min_x <= max_x && min_y <= max_y && min_z <= max_z, "box min above max")
endmodule

bind shape_world_aabb_unit swa_checker u_swa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .min_x(min_x), .min_y(min_y), .min_z(min_z),
  .max_x(max_x), .max_y(max_y), .max_z(max_z)
);
